### sv/nls_pkg.sv
// Package: shared types and constants for the numeric literal scanner.
`timescale 1ns / 1ps
package nls_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 64;
    localparam int KIND_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_ZERO  = 4'd1,
        PH_RDIG  = 4'd2,
        PH_DEC   = 4'd3,
        PH_FRAC  = 4'd4,
        PH_EXPD  = 4'd5,
        PH_SUFL  = 4'd6,
        PH_SUFU  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_HEX = 2'd1,
        RX_OCT = 2'd2,
        RX_BIN = 2'd3
    } radix_t;

    typedef enum logic [KIND_W-1:0] {
        K_I32 = 3'd0,
        K_I64 = 3'd1,
        K_U32 = 3'd2,
        K_U64 = 3'd3,
        K_F32 = 3'd4,
        K_F64 = 3'd5
    } kind_t;

    // One character after classification.
    typedef struct packed {
        logic [3:0] dig_val;  // digit worth, hex letters included
        logic       is_dec;
        logic       is_hex;
        logic       is_oct;
        logic       is_bin;
        logic       is_zero;
        logic       c_x;      // x or X
        logic       c_o;      // o or O
        logic       c_b;      // b or B
        logic       c_dot;
        logic       c_e;      // e or E
        logic       c_l;
        logic       c_u;
        logic       c_f;
        logic       last;
    } cls_t;

endpackage

### sv/nls_if.sv
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps
interface nls_in_if;
    logic                     valid;
    logic                     ready;
    logic [nls_pkg::CH_W-1:0] ch;
    logic                     last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface nls_out_if;
    logic                        valid;
    logic                        ready;
    logic [nls_pkg::VALUE_W-1:0] value;
    logic [nls_pkg::KIND_W-1:0]  kind;

    modport source (output valid, output value, output kind, input ready);
    modport sink   (input valid, input value, input kind, output ready);
endinterface

### sv/numeric_literal_scanner_unit.sv
// Top level: numeric literal scanner, classifier front end and scan back end.
// Throughput: one character beat per cycle, sustained while the result side keeps up.
// The beat that carries last is first written into the character queue and then, once the scan
// engine takes it, scans straight into the result register, which presents the result as valid.
// The scan state update (shift-add on the 64-bit accumulator) sets the cycle budget.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result and
// returns the scanner to the start of a literal with a zero accumulator.
`timescale 1ns / 1ps
module numeric_literal_scanner_unit (
    input  logic       clk,
    input  logic       rst_n,
    nls_in_if.sink     din,
    nls_out_if.source  dout
);
    import nls_pkg::*;

    // classifier -> queue
    logic push_valid;
    logic push_ready;
    cls_t push_data;

    // queue -> scan engine
    logic head_valid;
    logic head_ready;
    cls_t head;

    // Front end: decode each character into digit worth and class flags,
    // push straight into the queue; back-pressure comes from queue fullness.
    nls_classify u_classify (
        .din        (din),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple: the front keeps taking beats while the back waits on dout.
    nls_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head)
    );

    // Back end: advance the scan phase one classified beat at a time and
    // hold the finished value and kind in the result register.
    nls_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head),
        .dout       (dout)
    );

endmodule

### sv/nls_classify.sv
// Front end: accept character beats and classify them for the scanner.
`timescale 1ns / 1ps
module nls_classify (
    nls_in_if.sink         din,
    output logic           push_valid,
    input  logic           push_ready,
    output nls_pkg::cls_t  push_data
);
    import nls_pkg::*;

    logic [CH_W-1:0] c;
    cls_t            cls;

    assign c = din.ch;

    always_comb
    begin
        cls         = '0;
        cls.is_dec  = (c >= 8'h30) && (c <= 8'h39);
        cls.is_oct  = (c >= 8'h30) && (c <= 8'h37);
        cls.is_bin  = (c == 8'h30) || (c == 8'h31);
        cls.is_zero = (c == 8'h30);
        cls.c_x     = (c == 8'h78) || (c == 8'h58);
        cls.c_o     = (c == 8'h6F) || (c == 8'h4F);
        cls.c_b     = (c == 8'h62) || (c == 8'h42);
        cls.c_dot   = (c == 8'h2E);
        cls.c_e     = (c == 8'h65) || (c == 8'h45);
        cls.c_l     = (c == 8'h6C);
        cls.c_u     = (c == 8'h75);
        cls.c_f     = (c == 8'h66);
        cls.last    = din.last;
        if (cls.is_dec)
        begin
            cls.dig_val = c[3:0];
            cls.is_hex  = 1'b1;
        end
        else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
        begin
            // letters a-f / A-F: low three bits run 1..6, worth 10..15
            cls.dig_val = 4'(c[2:0] + 3'd1) + 4'd8;
            cls.is_hex  = 1'b1;
        end
    end

    assign push_valid = din.valid;
    assign din.ready  = push_ready;
    assign push_data  = cls;

endmodule

### sv/nls_queue.sv
// Short FIFO between the classifier and the scan engine.
`timescale 1ns / 1ps
module nls_queue #(
    parameter int Depth = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  nls_pkg::cls_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output nls_pkg::cls_t pop_data
);
    import nls_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cls_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/nls_exec.sv
// Back end: scan state machine, digit accumulator and result register.
`timescale 1ns / 1ps
module nls_exec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    output logic          head_ready,
    input  nls_pkg::cls_t head,
    nls_out_if.source     dout
);
    import nls_pkg::*;

    phase_t              phase_reg, phase_next;
    radix_t              radix_reg, radix_next;
    kind_t               kind_reg, kind_next;
    logic [VALUE_W-1:0]  accum_reg, accum_next;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    kind_t               out_kind_reg;
    logic                take;

    // decimal step, shared by several phases
    phase_t              dec_phase;
    kind_t               dec_kind;
    logic [VALUE_W-1:0]  dec_accum;
    // prefixed-radix digit step
    logic                rdig_ok;
    logic [VALUE_W-1:0]  rdig_accum;
    // float suffix step
    phase_t              flt_phase;

    assign head_ready = !out_valid_reg || dout.ready;
    assign take       = head_valid && head_ready;

    always_comb
    begin
        dec_phase = PH_DONE;
        dec_kind  = kind_reg;
        dec_accum = accum_reg;
        if (head.is_dec)
        begin
            dec_accum = (accum_reg << 3) + (accum_reg << 1) + VALUE_W'(head.dig_val);
            dec_phase = PH_DEC;
        end
        else if (head.c_dot)
        begin
            dec_kind  = K_F32;
            dec_phase = PH_FRAC;
        end
        else if (head.c_e)
        begin
            dec_kind  = K_F32;
            dec_phase = PH_EXPD;
        end
        else if (head.c_l)
        begin
            dec_kind  = K_I64;
            dec_phase = PH_SUFL;
        end
        else if (head.c_u)
        begin
            dec_kind  = K_U32;
            dec_phase = PH_SUFU;
        end
        else if (head.c_f)
        begin
            dec_kind = K_F32;
        end
        else
        begin
            dec_kind = K_I32;
        end
    end

    always_comb
    begin
        case (radix_reg)
            RX_HEX:
            begin
                rdig_ok    = head.is_hex;
                rdig_accum = (accum_reg << 4) | VALUE_W'(head.dig_val);
            end
            RX_OCT:
            begin
                rdig_ok    = head.is_oct;
                rdig_accum = (accum_reg << 3) | VALUE_W'(head.dig_val);
            end
            RX_BIN:
            begin
                rdig_ok    = head.is_bin;
                rdig_accum = (accum_reg << 1) | VALUE_W'(head.dig_val);
            end
            default:
            begin
                rdig_ok    = 1'b0;
                rdig_accum = accum_reg;
            end
        endcase
    end

    assign flt_phase = head.c_l ? PH_SUFL : PH_DONE;

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        kind_next  = kind_reg;
        accum_next = accum_reg;
        case (phase_reg)
            PH_START:
            begin
                if (head.is_zero)
                begin
                    phase_next = PH_ZERO;
                end
                else
                begin
                    phase_next = dec_phase;
                    kind_next  = dec_kind;
                    accum_next = dec_accum;
                end
            end
            PH_ZERO:
            begin
                if (head.c_x)
                begin
                    radix_next = RX_HEX;
                    phase_next = PH_RDIG;
                end
                else if (head.c_o)
                begin
                    radix_next = RX_OCT;
                    phase_next = PH_RDIG;
                end
                else if (head.c_b)
                begin
                    radix_next = RX_BIN;
                    phase_next = PH_RDIG;
                end
                else
                begin
                    phase_next = dec_phase;
                    kind_next  = dec_kind;
                    accum_next = dec_accum;
                end
            end
            PH_RDIG:
            begin
                if (rdig_ok)
                begin
                    accum_next = rdig_accum;
                end
                else if (head.c_l)
                begin
                    kind_next  = K_I64;
                    phase_next = PH_DONE;
                end
                else if (head.c_u)
                begin
                    kind_next  = K_U32;
                    phase_next = PH_SUFU;
                end
                else
                begin
                    kind_next  = K_I32;
                    phase_next = PH_DONE;
                end
            end
            PH_DEC:
            begin
                phase_next = dec_phase;
                kind_next  = dec_kind;
                accum_next = dec_accum;
            end
            PH_FRAC:
            begin
                if (!head.is_dec)
                begin
                    if (head.c_e)
                    begin
                        phase_next = PH_EXPD;
                    end
                    else
                    begin
                        kind_next  = K_F32;
                        phase_next = flt_phase;
                    end
                end
            end
            PH_EXPD:
            begin
                if (!head.is_dec)
                begin
                    kind_next  = K_F32;
                    phase_next = flt_phase;
                end
            end
            PH_SUFL:
            begin
                if (head.c_f)
                begin
                    kind_next = K_F64;
                end
                phase_next = PH_DONE;
            end
            PH_SUFU:
            begin
                if (head.c_l)
                begin
                    kind_next = K_U64;
                end
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            radix_reg     <= RX_DEC;
            kind_reg      <= K_I32;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && head.last)
            begin
                phase_reg     <= PH_START;
                radix_reg     <= RX_DEC;
                kind_reg      <= K_I32;
                accum_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    phase_reg <= phase_next;
                    radix_reg <= radix_next;
                    kind_reg  <= kind_next;
                    accum_reg <= accum_next;
                end
                if (dout.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && head.last)
        begin
            out_value_reg <= accum_next;
            out_kind_reg  <= kind_next;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.value = out_value_reg;
    assign dout.kind  = KIND_W'(out_kind_reg);

endmodule
